// ----- sv/mpdcc_pkg.sv -----
// ----------------------------------------------------------------------------
// mpdcc_pkg: shared types and constants of the pin debounce change counter
// Function and status codes, payload structs of both channels and the
// layout of one pin entry in the debounce table.
// ----------------------------------------------------------------------------
package mpdcc_pkg;

	localparam int unsigned TIME_W  = 48;
	localparam int unsigned PIN_W   = 6;
	localparam int unsigned DEB_W   = 16;
	localparam int unsigned APB_AW  = 3;
	localparam int unsigned APB_DW  = 32;

	// flash pins are reserved and never touched
	localparam logic [PIN_W-1:0] FLASH_LO = PIN_W'(6);
	localparam logic [PIN_W-1:0] FLASH_HI = PIN_W'(11);

	// register index (byte address bit 2)
	localparam logic REG_DEBOUNCE_MS = 1'b0;

	typedef enum logic [1:0] {
		FN_SAMPLE    = 2'd0,
		FN_WRITE_CNT = 2'd1,
		FN_START     = 2'd2,
		FN_STOP      = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_PIN     = 3'd1,
		ST_FLASH_PIN   = 3'd2,
		ST_WATCHED     = 3'd3,
		ST_NOT_WATCHED = 3'd4
	} status_t;

	typedef struct packed {
		func_t             func;
		logic [PIN_W-1:0]  pin;
		logic              level;
		logic [TIME_W-1:0] now_ms;
		logic [TIME_W-1:0] count_value;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [PIN_W-1:0]  pin_echo;
		logic              stable_level;
		logic              raw_level;
		logic [TIME_W-1:0] change_count;
		logic [TIME_W-1:0] last_change_ms;
		logic              committed;
	} rsp_t;

	typedef struct packed {
		logic              raw_bit;
		logic              stable_bit;
		logic [TIME_W-1:0] raw_ms;
		logic [TIME_W-1:0] stable_ms;
		logic [TIME_W-1:0] count;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// ----- sv/mpdcc_ram.sv -----
// ----------------------------------------------------------------------------
// mpdcc_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered, old data returned
// on a read of the address written at the same edge.
// ----------------------------------------------------------------------------
module mpdcc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/multi_pin_debounce_change_counter_unit.sv -----
// ----------------------------------------------------------------------------
// multi_pin_debounce_change_counter_unit: per-pin debouncer with change count
// Path: stage 1 holds an accepted word while its entry is read, then the
// response register holds its response. Throughput: one word per cycle while
// rsp_stall is low; a read meeting the write-back of the word ahead on the
// same pin is bypassed, so back-to-back hits on a pin need no bubble.
// Reset: clears the watched flags, both valid stages and debounce_ms; the
// table RAM is not cleared (an entry is only used while its pin is watched).
// ----------------------------------------------------------------------------
module multi_pin_debounce_change_counter_unit #(
	parameter int unsigned NUM_PINS = 40
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               req_valid,
	output logic                               req_stall,
	input  mpdcc_pkg::req_t                    req,
	// response channel
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output mpdcc_pkg::rsp_t                    rsp,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mpdcc_pkg::APB_AW-1:0]       paddr,
	input  logic [mpdcc_pkg::APB_DW-1:0]       pwdata,
	output logic [mpdcc_pkg::APB_DW-1:0]       prdata,
	output logic                               pready
);

	import mpdcc_pkg::*;

	localparam int unsigned IDX_W = $clog2(NUM_PINS);
	localparam logic [PIN_W:0] NUM_PINS_L = (PIN_W+1)'(NUM_PINS);

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [DEB_W-1:0] debounce_ms_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DEBOUNCE_MS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ms_q <= '0;
		end else if (cfg_wr) begin
			debounce_ms_q <= pwdata[DEB_W-1:0];
		end
	end

	// read back the register; addresses beyond it read zero
	assign prdata = (paddr[2] == REG_DEBOUNCE_MS) ?
		{{(APB_DW-DEB_W){1'b0}}, debounce_ms_q} : '0;

	// ------------------------------------------------------------------
	// Handshake: stage 1 holds the word whose table entry is being read,
	// the response register holds the finished word.
	// ------------------------------------------------------------------
	logic   valid_s1;
	req_t   req_s1;
	logic   adv_s1;
	logic   acc;
	logic   rsp_valid_q;
	rsp_t   rsp_q;

	// stage 1 moves on whenever the response register is free or drained
	assign adv_s1    = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !adv_s1;
	assign acc       = req_valid && !req_stall;

	// ------------------------------------------------------------------
	// Pin table: watched flags in flops, entry payload in RAM
	// ------------------------------------------------------------------
	logic [NUM_PINS-1:0] watched_q;
	logic [ENTRY_W-1:0]  rdata;
	logic                wr_en;
	entry_t              ent_n;
	logic [IDX_W-1:0]    idx_s1;

	assign idx_s1 = req_s1.pin[IDX_W-1:0];

	mpdcc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_PINS)
	) u_tbl (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx_s1),
		.wdata (ent_n),
		.re    (acc),
		.raddr (req.pin[IDX_W-1:0]),
		.rdata (rdata)
	);

	// Bypass: the RAM returns old data when this word's read coincides with
	// the write-back of the word ahead of it to the same pin. Capture the
	// written entry instead.
	logic   byp_hit_s1;
	entry_t byp_ent_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_s1     <= req;
			byp_hit_s1 <= wr_en && (req_s1.pin == req.pin);
			byp_ent_s1 <= ent_n;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: decode the function and update the entry
	// ------------------------------------------------------------------
	entry_t            ent;
	logic              in_range;
	logic              flash;
	logic              watched;
	logic              watched_n;
	status_t           st;
	logic              commit;
	logic [TIME_W-1:0] elapsed;
	logic [TIME_W-1:0] cnt_inc;
	rsp_t              rsp_n;

	assign ent      = byp_hit_s1 ? byp_ent_s1 : entry_t'(rdata);
	assign in_range = {1'b0, req_s1.pin} < NUM_PINS_L;
	assign flash    = (req_s1.pin >= FLASH_LO) && (req_s1.pin <= FLASH_HI);
	assign watched  = in_range && watched_q[idx_s1];
	assign elapsed  = req_s1.now_ms - ent.raw_ms;
	assign cnt_inc  = ent.count + TIME_W'(1);

	always_comb begin
		st        = ST_OK;
		ent_n     = ent;
		watched_n = watched;
		commit    = 1'b0;
		if (!in_range) begin
			st = ST_BAD_PIN;
		end else if (flash) begin
			st = ST_FLASH_PIN;
		end else if (req_s1.func == FN_START) begin
			if (watched) begin
				st = ST_WATCHED;
			end else begin
				// start: both levels take the sample, both times take now
				watched_n        = 1'b1;
				ent_n.raw_bit    = req_s1.level;
				ent_n.stable_bit = req_s1.level;
				ent_n.raw_ms     = req_s1.now_ms;
				ent_n.stable_ms  = req_s1.now_ms;
				ent_n.count      = '0;
			end
		end else if (!watched) begin
			st = ST_NOT_WATCHED;
		end else if (req_s1.func == FN_STOP) begin
			watched_n = 1'b0;
		end else if (req_s1.func == FN_WRITE_CNT) begin
			ent_n.count = req_s1.count_value;
		end else if (req_s1.level != ent.raw_bit) begin
			// new raw level; commit at once when no debounce time is set
			ent_n.raw_bit = req_s1.level;
			ent_n.raw_ms  = req_s1.now_ms;
			if (debounce_ms_q == '0) begin
				ent_n.stable_bit = req_s1.level;
				ent_n.stable_ms  = req_s1.now_ms;
				ent_n.count      = cnt_inc;
				commit           = 1'b1;
			end
		end else if ((ent.stable_bit != ent.raw_bit) &&
				(elapsed >= {{(TIME_W-DEB_W){1'b0}}, debounce_ms_q})) begin
			// raw level held long enough: commit it
			ent_n.stable_bit = ent.raw_bit;
			ent_n.stable_ms  = ent.raw_ms;
			ent_n.count      = cnt_inc;
			commit           = 1'b1;
		end
	end

	assign wr_en = adv_s1 && (st == ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watched_q <= '0;
		end else if (wr_en) begin
			watched_q[idx_s1] <= watched_n;
		end
	end

	// response word shows the entry after the update; unwatched pins read
	// as level zero, time zero and an all-ones count
	always_comb begin
		rsp_n.status    = st;
		rsp_n.pin_echo  = req_s1.pin;
		rsp_n.committed = commit;
		if (watched_n) begin
			rsp_n.stable_level   = ent_n.stable_bit;
			rsp_n.raw_level      = ent_n.raw_bit;
			rsp_n.change_count   = ent_n.count;
			rsp_n.last_change_ms = ent_n.stable_ms;
		end else begin
			rsp_n.stable_level   = 1'b0;
			rsp_n.raw_level      = 1'b0;
			rsp_n.change_count   = '1;
			rsp_n.last_change_ms = '0;
		end
	end

	// ------------------------------------------------------------------
	// Response register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_q <= rsp_n;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- sv/mpdcc_checker.sv -----
// ----------------------------------------------------------------------------
// mpdcc_checker: port-level checks of the debounce change counter
// Watches the response channel for consistent status, commit and fields.
// ----------------------------------------------------------------------------
module mpdcc_checker #(
	parameter int unsigned NUM_PINS = 40
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rsp_valid,
	input  logic                         rsp_stall,
	input  mpdcc_pkg::rsp_t              rsp
);

	import mpdcc_pkg::*;

	localparam logic [PIN_W:0] NUM_PINS_L = (PIN_W+1)'(NUM_PINS);

	// a held response word does not change
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// only a successful item can commit, and a commit leaves stable == raw
	a_commit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.committed |->
			rsp.status == ST_OK && rsp.stable_level == rsp.raw_level)
		else $error("commit on failed item or stable differs from raw");

	// out-of-range pins always report an invalid pin
	a_bad_pin: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ({1'b0, rsp.pin_echo} >= NUM_PINS_L) |->
			rsp.status == ST_BAD_PIN)
		else $error("out-of-range pin not rejected");

	// rejected pins read as unwatched
	a_bad_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_BAD_PIN || rsp.status == ST_FLASH_PIN) |->
			rsp.change_count == '1 && rsp.last_change_ms == '0 &&
			!rsp.stable_level && !rsp.raw_level)
		else $error("rejected pin shows table contents");

endmodule

bind multi_pin_debounce_change_counter_unit mpdcc_checker #(
	.NUM_PINS (NUM_PINS)
) u_mpdcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: regression for the multi-pin debounce change counter unit
// Drives request words with random gaps, stalls the response side in random
// bursts and predicts every response word from a per-pin model of the
// debounce table. The debounce time is set over APB between phases.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mpdcc_pkg::*;

	localparam int unsigned PINS       = 40;
	localparam int unsigned SETTLE     = 6;        // cycles waited past drain for the pipe to settle
	localparam int unsigned TIMEOUT_NS = 4_000_000;
	localparam int unsigned PHASE_LEN  = 245;
	localparam logic [TIME_W-1:0] ALL_ONES48 = '1;
	localparam logic [APB_AW-1:0] DEB_ADDR   = {REG_DEBOUNCE_MS, 2'b00};

	// Per-pin model of the debounce table; predicts one response word per
	// request word and checks responses in order.
	class debounce_tracker;
		bit              watched   [64];
		bit              raw_lvl   [64];
		bit              stable_lvl[64];
		bit [TIME_W-1:0] raw_ms    [64];
		bit [TIME_W-1:0] stable_ms [64];
		bit [TIME_W-1:0] count     [64];
		bit [DEB_W-1:0]  debounce;
		rsp_t            pending_rsp[$];
		int unsigned     errors;
		int unsigned     commits;
		int unsigned     rejects;

		function new();
			debounce = '0;
			errors   = 0;
			commits  = 0;
			rejects  = 0;
			foreach (watched[i]) watched[i] = 1'b0;
		endfunction

		function void note_request(req_t w);
			rsp_t            e;
			int unsigned     p;
			bit [TIME_W-1:0] elapsed;
			p = 32'(w.pin);
			e = '0;
			e.status = ST_OK;
			e.pin_echo = w.pin;
			if (p >= PINS) begin
				e.status = ST_BAD_PIN;
			end else if (w.pin >= FLASH_LO && w.pin <= FLASH_HI) begin
				e.status = ST_FLASH_PIN;
			end else if (w.func == FN_START) begin
				if (watched[p]) begin
					e.status = ST_WATCHED;
				end else begin
					watched[p]    = 1'b1;
					raw_lvl[p]    = w.level;
					stable_lvl[p] = w.level;
					raw_ms[p]     = w.now_ms;
					stable_ms[p]  = w.now_ms;
					count[p]      = '0;
				end
			end else if (!watched[p]) begin
				e.status = ST_NOT_WATCHED;
			end else begin
				case (w.func)
					FN_STOP: begin
						watched[p] = 1'b0;
					end
					FN_WRITE_CNT: begin
						count[p] = w.count_value;
					end
					default: begin
						elapsed = w.now_ms - raw_ms[p];
						if (w.level != raw_lvl[p]) begin
							raw_lvl[p] = w.level;
							raw_ms[p]  = w.now_ms;
							if (debounce == '0) e.committed = 1'b1;
						end else if (stable_lvl[p] != raw_lvl[p] &&
						             elapsed >= TIME_W'(debounce)) begin
							e.committed = 1'b1;
						end
					end
				endcase
				if (e.committed) begin
					stable_lvl[p] = raw_lvl[p];
					stable_ms[p]  = raw_ms[p];
					count[p]      = count[p] + TIME_W'(1);
				end
			end
			if (p < PINS && watched[p]) begin
				e.stable_level   = stable_lvl[p];
				e.raw_level      = raw_lvl[p];
				e.change_count   = count[p];
				e.last_change_ms = stable_ms[p];
			end else begin
				e.change_count = '1;
			end
			if (e.status != ST_OK) rejects++;
			if (e.committed) commits++;
			pending_rsp = {pending_rsp, e};
		endfunction

		function void match_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (pending_rsp.size() == 0) begin
				errors++;
				$display("%0t: response word with none expected, expected none actual %h",
				         $time, got);
				return;
			end
			want = pending_rsp.pop_front();
			match_field("status",         64'(want.status),         64'(got.status));
			match_field("pin_echo",       64'(want.pin_echo),       64'(got.pin_echo));
			match_field("stable_level",   64'(want.stable_level),   64'(got.stable_level));
			match_field("raw_level",      64'(want.raw_level),      64'(got.raw_level));
			match_field("change_count",   64'(want.change_count),   64'(got.change_count));
			match_field("last_change_ms", 64'(want.last_change_ms), 64'(got.last_change_ms));
			match_field("committed",      64'(want.committed),      64'(got.committed));
		endfunction
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	req_t                req       = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	rsp_t                rsp;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [APB_AW-1:0]   paddr     = '0;
	logic [APB_DW-1:0]   pwdata    = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	debounce_tracker track = new();
	bit          calm = 1'b0;      // no idling on either side when set
	int          stall_left = 0;
	int unsigned words_sent = 0;
	int unsigned settings_seen = 0;

	multi_pin_debounce_change_counter_unit #(
		.NUM_PINS(PINS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Watch both handshakes at the edge: note each accepted request before
	// checking the response of the same edge (the pipe is two deep, so a
	// response never belongs to the request of its own edge).
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) track.note_request(req);
			if (rsp_valid && !rsp_stall) track.check_response(rsp);
		end
	end

	// Stall the response side in random bursts; drop stall for good
	// once the run goes calm.
	always @(posedge clk) begin
		if (calm) begin
			stall_left = 0;
			rsp_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			rsp_stall <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 13);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	function automatic logic [TIME_W-1:0] rand48();
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		return v[TIME_W-1:0];
	endfunction

	// Pick a pin that is neither a flash pin nor out of range.
	function automatic int valid_pin();
		int r;
		r = $urandom_range(0, PINS - 7);
		return (r < int'(FLASH_LO)) ? r : r + 6;
	endfunction

	// Present one word, optionally after a random gap, and hold it until
	// accepted. Valid stays high when the next word follows back to back.
	task automatic send_word(input req_t w);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		words_sent++;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic issue(input func_t f, input int pin, input bit lvl,
	                     input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] c);
		req_t w;
		w.func        = f;
		w.pin         = PIN_W'(pin);
		w.level       = lvl;
		w.now_ms      = t;
		w.count_value = c;
		send_word(w);
	endtask

	// Drop valid, wait for every expected word, then let the pipe settle.
	// The first edge lets the monitor note a word accepted at this edge.
	task automatic drain_and_settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (track.pending_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write debounce_ms over APB on an idle block, then read it back.
	task automatic write_debounce(input logic [DEB_W-1:0] value);
		drain_and_settle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= DEB_ADDR;
		pwdata  <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		track.debounce = value;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		track.match_field("prdata", 64'(value), 64'(prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
		settings_seen++;
	endtask

	// Random phase: mostly well-formed traffic on a small pool of watched
	// candidates with time moving forward, plus some noise words on any pin.
	task automatic run_random(input logic [DEB_W-1:0] deb, input int n,
	                          input logic [TIME_W-1:0] start_ms);
		req_t            w;
		logic [TIME_W-1:0] clock_ms;
		int              pool[4];
		int              roll;
		int              k;
		int              slot;
		bit              last_lvl[64];
		write_debounce(deb);
		clock_ms = start_ms;
		for (k = 0; k < 4; k++) pool[k] = valid_pin();
		for (k = 0; k < n; k++) begin
			// hold off the sender once per non-calm phase until all words are back
			if (k == n / 2 && !calm) drain_and_settle();
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				w.func        = func_t'($urandom_range(0, 3));
				w.pin         = PIN_W'($urandom_range(0, 63));
				w.level       = 1'($urandom_range(0, 1));
				w.now_ms      = rand48();
				w.count_value = rand48();
			end else begin
				if (roll < 13) pool[$urandom_range(0, 3)] = valid_pin();
				slot = pool[$urandom_range(0, 3)];
				roll = $urandom_range(0, 99);
				w.func = (roll < 72) ? FN_SAMPLE :
				         (roll < 80) ? FN_WRITE_CNT :
				         (roll < 93) ? FN_START : FN_STOP;
				w.pin = PIN_W'(slot);
				// keep the level mostly steady so debounce windows can expire
				if ($urandom_range(0, 9) < 3) last_lvl[slot] = ~last_lvl[slot];
				w.level = last_lvl[slot];
				clock_ms = clock_ms + TIME_W'($urandom_range(0, deb / 2 + 2));
				w.now_ms = clock_ms;
				w.count_value = ($urandom_range(0, 3) == 0) ?
				                ALL_ONES48 - TIME_W'($urandom_range(0, 2)) : rand48();
			end
			send_word(w);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: immediate commits, status codes, counter wrap
		write_debounce('0);
		issue(FN_START,     0,  1'b0, '0,        ALL_ONES48);
		issue(FN_START,     0,  1'b1, 48'd1,     '0);          // already watched
		issue(FN_SAMPLE,    0,  1'b1, 48'd5,     '0);          // commits at once
		issue(FN_WRITE_CNT, 0,  1'b0, 48'd5,     ALL_ONES48);
		issue(FN_SAMPLE,    0,  1'b0, 48'd6,     '0);          // counter wraps to zero
		issue(FN_SAMPLE,    0,  1'b0, 48'd7,     '0);          // stable equals raw
		issue(FN_STOP,      0,  1'b0, 48'd8,     '0);
		issue(FN_SAMPLE,    0,  1'b1, 48'd9,     '0);          // not watched
		issue(FN_WRITE_CNT, 0,  1'b0, 48'd9,     ALL_ONES48);
		issue(FN_STOP,      0,  1'b0, 48'd9,     '0);
		issue(FN_START,     6,  1'b1, 48'd10,    '0);          // flash pins
		issue(FN_SAMPLE,    11, 1'b1, 48'd10,    '0);
		issue(FN_START,     40, 1'b1, 48'd10,    '0);          // out of range
		issue(FN_SAMPLE,    63, 1'b1, ALL_ONES48, ALL_ONES48);
		issue(FN_START,     39, 1'b1, ALL_ONES48, '0);
		issue(FN_START,     5,  1'b0, ALL_ONES48, '0);
		issue(FN_START,     12, 1'b1, '0,        '0);

		// directed: longest debounce, time stamps across the 48-bit wrap
		write_debounce('1);
		issue(FN_SAMPLE,    39, 1'b0, 48'd1,     '0);          // raw change only
		issue(FN_SAMPLE,    39, 1'b0, 48'd65535, '0);          // one ms short
		issue(FN_SAMPLE,    39, 1'b0, 48'd65536, '0);          // exactly enough
		issue(FN_SAMPLE,    39, 1'b0, 48'd65537, '0);
		issue(FN_SAMPLE,    5,  1'b1, 48'd10,    '0);
		issue(FN_SAMPLE,    5,  1'b0, 48'd20,    '0);          // bounce back
		issue(FN_STOP,      39, 1'b0, 48'd30,    '0);
		issue(FN_STOP,      12, 1'b0, 48'd30,    '0);

		// random phases over several debounce settings
		run_random('0, PHASE_LEN, rand48());
		run_random('1, PHASE_LEN, ALL_ONES48 - 48'd200000);
		run_random(16'd1, PHASE_LEN, rand48());
		run_random(DEB_W'($urandom_range(2, 200)), PHASE_LEN, rand48());
		calm = 1'b1;
		run_random(DEB_W'($urandom_range(0, 65535)), PHASE_LEN, rand48());

		drain_and_settle();
		$display("covered %0d request words over %0d debounce settings", words_sent,
		         settings_seen);
		$display("saw %0d commits and %0d rejected words", track.commits, track.rejects);
		if (track.errors == 0 && track.pending_rsp.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d words outstanding", track.pending_rsp.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- files.f -----
sv/mpdcc_pkg.sv
sv/mpdcc_ram.sv
sv/multi_pin_debounce_change_counter_unit.sv
sv/mpdcc_checker.sv
verif/testbench.sv
